@@ rtl/core/wdcm_pkg.sv @@
// Shared types, codes and constants of the weighted distance cost matrix.
package wdcm_pkg;

  // Field widths
  localparam int COORD_W    = 24;
  localparam int NUM_FIELDS = 4;
  localparam int WORD_W     = NUM_FIELDS * COORD_W;
  localparam int WEIGHT_W   = 16;
  localparam int COST_W     = 32;
  localparam int INDEX_W    = 9;
  localparam int ACTION_W   = 2;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;

  // Distance datapath widths
  localparam int MAG_W      = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W + 1;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int ACC_W      = 64;
  localparam int FIELD_IDX_W = $clog2(NUM_FIELDS);
  localparam int ROOT_STEPS = 32;
  localparam int ITER_W     = $clog2(ROOT_STEPS);

  // Configuration port
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;
  localparam int REG_IDX_W  = CFG_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_X_WEIGHT       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_Y_WEIGHT       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Z_WEIGHT       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_WEIGHT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNMATCHED_COST = 3'd4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 16'd256;
  localparam logic [COST_W-1:0]   UNMATCHED_RESET = 32'd0;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_APPEND_FIRST  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND_SECOND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY         = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR         = 2'd3;

  // Entry kinds
  localparam logic [KIND_W-1:0] KIND_DIST      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNMATCHED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO      = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [NUM_FIELDS-1:0][WEIGHT_W-1:0] weight;
    logic [COST_W-1:0]                   unmatched_cost;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
  } dist_req_t;

  typedef struct packed {
    logic              done;
    logic [COST_W-1:0] cost;
  } dist_rsp_t;

endpackage

@@ rtl/core/wdcm_req_if.sv @@
// Request channel interface: action, point fields and matrix indices.
interface wdcm_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [wdcm_pkg::ACTION_W-1:0]         action;
  logic signed [wdcm_pkg::COORD_W-1:0]   pos_x;
  logic signed [wdcm_pkg::COORD_W-1:0]   pos_y;
  logic signed [wdcm_pkg::COORD_W-1:0]   pos_z;
  logic signed [wdcm_pkg::COORD_W-1:0]   scalar_value;
  logic [wdcm_pkg::INDEX_W-1:0]          row;
  logic [wdcm_pkg::INDEX_W-1:0]          column;

  modport source (
    output valid, action, pos_x, pos_y, pos_z, scalar_value, row, column,
    input  ready
  );

  modport sink (
    input  valid, action, pos_x, pos_y, pos_z, scalar_value, row, column,
    output ready
  );
endinterface

@@ rtl/core/wdcm_rsp_if.sv @@
// Response channel interface: cost, entry kind and status.
interface wdcm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [wdcm_pkg::COST_W-1:0]     cost;
  logic [wdcm_pkg::KIND_W-1:0]     entry_kind;
  logic [wdcm_pkg::STATUS_W-1:0]   status;

  modport source (
    output valid, cost, entry_kind, status,
    input  ready
  );

  modport sink (
    input  valid, cost, entry_kind, status,
    output ready
  );
endinterface

@@ rtl/core/wdcm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wdcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/wdcm_cfg.sv @@
// APB-style configuration registers: four weights and the unmatched cost.
module wdcm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wdcm_pkg::CFG_AW-1:0] paddr,
  input  logic [wdcm_pkg::CFG_DW-1:0] pwdata,
  output logic [wdcm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output wdcm_pkg::cfg_t              cfg_o
);

  wdcm_pkg::cfg_t                     cfg_q, cfg_d;
  logic [wdcm_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                               wr_en;

  assign reg_idx = paddr[wdcm_pkg::CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        wdcm_pkg::REG_X_WEIGHT:       cfg_d.weight[0] = pwdata[wdcm_pkg::WEIGHT_W-1:0];
        wdcm_pkg::REG_Y_WEIGHT:       cfg_d.weight[1] = pwdata[wdcm_pkg::WEIGHT_W-1:0];
        wdcm_pkg::REG_Z_WEIGHT:       cfg_d.weight[2] = pwdata[wdcm_pkg::WEIGHT_W-1:0];
        wdcm_pkg::REG_VALUE_WEIGHT:   cfg_d.weight[3] = pwdata[wdcm_pkg::WEIGHT_W-1:0];
        wdcm_pkg::REG_UNMATCHED_COST: cfg_d.unmatched_cost = pwdata[wdcm_pkg::COST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight[0]      <= wdcm_pkg::WEIGHT_RESET;
      cfg_q.weight[1]      <= wdcm_pkg::WEIGHT_RESET;
      cfg_q.weight[2]      <= wdcm_pkg::WEIGHT_RESET;
      cfg_q.weight[3]      <= wdcm_pkg::WEIGHT_RESET;
      cfg_q.unmatched_cost <= wdcm_pkg::UNMATCHED_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      wdcm_pkg::REG_X_WEIGHT:       prdata = wdcm_pkg::CFG_DW'(cfg_q.weight[0]);
      wdcm_pkg::REG_Y_WEIGHT:       prdata = wdcm_pkg::CFG_DW'(cfg_q.weight[1]);
      wdcm_pkg::REG_Z_WEIGHT:       prdata = wdcm_pkg::CFG_DW'(cfg_q.weight[2]);
      wdcm_pkg::REG_VALUE_WEIGHT:   prdata = wdcm_pkg::CFG_DW'(cfg_q.weight[3]);
      wdcm_pkg::REG_UNMATCHED_COST: prdata = wdcm_pkg::CFG_DW'(cfg_q.unmatched_cost);
      default:                      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/wdcm_dist.sv @@
// Distance unit: shared 25x25 multiplier for weighted squares, then a bitwise root.
module wdcm_dist (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  wdcm_pkg::dist_req_t                                   req_i,
  input  logic [wdcm_pkg::NUM_FIELDS-1:0][wdcm_pkg::WEIGHT_W-1:0] weight_i,
  output wdcm_pkg::dist_rsp_t                                   rsp_o
);

  localparam int MAG_W  = wdcm_pkg::MAG_W;
  localparam int SQ_W   = wdcm_pkg::SQ_W;
  localparam int PROD_W = wdcm_pkg::PROD_W;
  localparam int ACC_W  = wdcm_pkg::ACC_W;
  localparam int NF     = wdcm_pkg::NUM_FIELDS;
  localparam int CW     = wdcm_pkg::COORD_W;
  localparam int FW     = wdcm_pkg::FIELD_IDX_W;
  localparam int IW     = wdcm_pkg::ITER_W;

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_SQ   = 3'd1;
  localparam logic [2:0] D_LO   = 3'd2;
  localparam logic [2:0] D_HI   = 3'd3;
  localparam logic [2:0] D_SUM  = 3'd4;
  localparam logic [2:0] D_ACC  = 3'd5;
  localparam logic [2:0] D_ROOT = 3'd6;
  localparam logic [2:0] D_DONE = 3'd7;

  localparam logic [FW-1:0] LAST_FIELD = FW'(NF - 1);
  localparam logic [IW-1:0] LAST_STEP  = IW'(wdcm_pkg::ROOT_STEPS - 1);
  localparam logic [ACC_W-1:0] BIT_INIT = ACC_W'(1) << (ACC_W - 2);

  logic [2:0]    state_q, state_d;
  logic [FW-1:0] idx_q, idx_d;
  logic [IW-1:0] iter_q, iter_d;

  logic [NF-1:0][MAG_W-1:0] mag_q, mag_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [SQ_W-MAG_W-1:0]    sq_hi_q, sq_hi_d;
  logic [ACC_W-1:0]         term_q, term_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [ACC_W-1:0]         num_q, num_d;
  logic [ACC_W-1:0]         res_q, res_d;
  logic [ACC_W-1:0]         bit_q, bit_d;

  logic [MAG_W-1:0]         diff [NF];
  logic [MAG_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [MAG_W-1:0]         w_sel;
  logic [ACC_W:0]           sum_ext;
  logic [ACC_W-1:0]         acc_sat;
  logic [ACC_W-1:0]         trial;

  // Per-field absolute differences, taken once when the pair arrives
  always_comb begin
    for (int k = 0; k < NF; k++) begin
      diff[k] = {req_i.word_a[k*CW+CW-1], req_i.word_a[k*CW +: CW]}
              - {req_i.word_b[k*CW+CW-1], req_i.word_b[k*CW +: CW]};
      mag_d[k] = diff[k][MAG_W-1] ? (~diff[k] + 1'b1) : diff[k];
    end
  end

  assign w_sel = MAG_W'(weight_i[idx_q]);

  // Operand select for the shared multiplier
  always_comb begin
    case (state_q)
      D_SQ: begin
        mul_a = mag_q[idx_q];
        mul_b = mag_q[idx_q];
      end
      D_LO: begin
        mul_a = prod_q[MAG_W-1:0];
        mul_b = w_sel;
      end
      D_HI: begin
        mul_a = MAG_W'(sq_hi_q);
        mul_b = w_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign sum_ext = {1'b0, acc_q} + {1'b0, term_q};
  assign acc_sat = sum_ext[ACC_W] ? {ACC_W{1'b1}} : sum_ext[ACC_W-1:0];
  assign trial   = res_q + bit_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    iter_d  = iter_q;
    prod_d  = prod_q;
    sq_hi_d = sq_hi_q;
    term_d  = term_q;
    acc_d   = acc_q;
    num_d   = num_q;
    res_d   = res_q;
    bit_d   = bit_q;
    case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          acc_d   = '0;
          idx_d   = '0;
          state_d = D_SQ;
        end
      end
      D_SQ: begin
        prod_d  = mul_p;
        state_d = D_LO;
      end
      D_LO: begin
        sq_hi_d = prod_q[SQ_W-1:MAG_W];
        prod_d  = mul_p;
        state_d = D_HI;
      end
      D_HI: begin
        term_d  = ACC_W'(prod_q);
        prod_d  = mul_p;
        state_d = D_SUM;
      end
      D_SUM: begin
        term_d  = term_q + {prod_q[ACC_W-MAG_W-1:0], {MAG_W{1'b0}}};
        state_d = D_ACC;
      end
      D_ACC: begin
        acc_d = acc_sat;
        if (idx_q == LAST_FIELD) begin
          num_d   = acc_sat;
          res_d   = '0;
          bit_d   = BIT_INIT;
          iter_d  = '0;
          state_d = D_ROOT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = D_SQ;
        end
      end
      D_ROOT: begin
        if (num_q >= trial) begin
          num_d = num_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d  = bit_q >> 2;
        iter_d = iter_q + 1'b1;
        if (iter_q == LAST_STEP) begin
          state_d = D_DONE;
        end
      end
      D_DONE: begin
        state_d = D_IDLE;
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      idx_q   <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && req_i.start) begin
      mag_q <= mag_d;
    end
    prod_q  <= prod_d;
    sq_hi_q <= sq_hi_d;
    term_q  <= term_d;
    acc_q   <= acc_d;
    num_q   <= num_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
  end

  // Q16.16 root truncated to Q20.12
  assign rsp_o.done = (state_q == D_DONE);
  assign rsp_o.cost = {4'd0, res_q[wdcm_pkg::COST_W-1:4]};

endmodule

@@ rtl/core/weighted_distance_cost_matrix.sv @@
// Top level of the weighted distance cost matrix: point stores, sequencer, result register.
//
//   Channel  Dir  Transfer when          Carries
//   req_i    in   valid && ready         action, pos_x/y/z, scalar_value, row, column
//   rsp_o    out  valid && ready         cost, entry_kind, status
//   APB      in   psel&&penable&&pwrite  x/y/z/value weight, unmatched cost
//
// Appends, clears and queries that land outside the distance block put their result in
// the output register on the next cycle.
// A distance query reads both points from the stores, starts the distance unit, then
// runs each field through the shared multiplier (square, two weight partial products, add,
// saturating add), then the bitwise square root, and finally loads the result; no new
// transfer is taken until that result is loaded.
// Reset zeroes both set counts and loads the default weights; the stores come up
// undefined and need no clearing pass, since a query reads only written slots.
// A result held by rsp_o stall blocks new transfers; one is taken in the cycle the
// held result is transferred.
module weighted_distance_cost_matrix #(
  parameter int MAX_POINTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wdcm_req_if.sink                    req_i,
  wdcm_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wdcm_pkg::CFG_AW-1:0] paddr,
  input  logic [wdcm_pkg::CFG_DW-1:0] pwdata,
  output logic [wdcm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int SLOTS = 2 * MAX_POINTS;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  // Compare width for matrix indices against the padded size
  localparam int XW    = (CW + 1 > wdcm_pkg::INDEX_W) ? CW + 1 : wdcm_pkg::INDEX_W;

  localparam logic [CW-1:0] CNT_FULL    = CW'(MAX_POINTS);
  localparam logic [AW-1:0] SECOND_BASE = AW'(MAX_POINTS);

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_RDA   = 3'd1;
  localparam logic [2:0] T_RDB   = 3'd2;
  localparam logic [2:0] T_START = 3'd3;
  localparam logic [2:0] T_WAIT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] first_q, first_d;
  logic [CW-1:0] second_q, second_d;
  logic [AW-1:0] slot_a_q, slot_a_d;
  logic [AW-1:0] slot_b_q, slot_b_d;
  logic [wdcm_pkg::WORD_W-1:0] word_a_q;

  logic                            out_valid_q, out_valid_d;
  logic [wdcm_pkg::COST_W-1:0]     cost_q, cost_d;
  logic [wdcm_pkg::KIND_W-1:0]     kind_q, kind_d;
  logic [wdcm_pkg::STATUS_W-1:0]   status_q, status_d;
  logic                            out_load;

  logic                        req_ready;
  logic                        req_fire;
  logic                        sel_second;
  logic [CW-1:0]               cnt_sel;
  logic [CW:0]                 size_n;
  logic [XW-1:0]               row_x, col_x, size_x, first_x, second_x;
  logic                        out_range;
  logic                        in_row, in_col;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  logic [wdcm_pkg::WORD_W-1:0] ram_wdata;
  logic [wdcm_pkg::WORD_W-1:0] ram_rdata;

  wdcm_pkg::cfg_t      cfg;
  wdcm_pkg::dist_req_t dist_req;
  wdcm_pkg::dist_rsp_t dist_rsp;

  wdcm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // One word per slot holds all four fields of a point
  wdcm_ram #(
    .WIDTH (wdcm_pkg::WORD_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wdcm_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (dist_req),
    .weight_i (cfg.weight),
    .rsp_o    (dist_rsp)
  );

  // Take a new transfer only when idle and the result register is free or draining
  assign req_ready   = (state_q == T_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_ready;
  assign req_i.ready = req_ready;

  assign ram_wdata = {req_i.scalar_value, req_i.pos_z, req_i.pos_y, req_i.pos_x};
  assign ram_raddr = (state_q == T_RDA) ? slot_a_q : slot_b_q;

  // Padded matrix size is zero unless both sets hold points
  assign size_n    = (first_q != '0 && second_q != '0)
                   ? ({1'b0, first_q} + {1'b0, second_q}) : '0;
  assign row_x     = XW'(req_i.row);
  assign col_x     = XW'(req_i.column);
  assign size_x    = XW'(size_n);
  assign first_x   = XW'(first_q);
  assign second_x  = XW'(second_q);
  assign out_range = (row_x >= size_x) || (col_x >= size_x);
  assign in_row    = row_x < first_x;
  assign in_col    = col_x < second_x;

  assign sel_second = (req_i.action == wdcm_pkg::ACT_APPEND_SECOND);
  assign cnt_sel    = sel_second ? second_q : first_q;

  assign dist_req.start  = (state_q == T_START);
  assign dist_req.word_a = word_a_q;
  assign dist_req.word_b = ram_rdata;

  always_comb begin
    state_d   = state_q;
    first_d   = first_q;
    second_d  = second_q;
    slot_a_d  = slot_a_q;
    slot_b_d  = slot_b_q;
    ram_we    = 1'b0;
    ram_waddr = sel_second ? SECOND_BASE + AW'(cnt_sel) : AW'(cnt_sel);
    out_load  = 1'b0;
    cost_d    = '0;
    kind_d    = wdcm_pkg::KIND_DIST;
    status_d  = wdcm_pkg::ST_OK;

    case (state_q)
      T_IDLE: begin
        if (req_fire) begin
          case (req_i.action)
            wdcm_pkg::ACT_APPEND_FIRST, wdcm_pkg::ACT_APPEND_SECOND: begin
              out_load = 1'b1;
              if (cnt_sel >= CNT_FULL) begin
                status_d = wdcm_pkg::ST_FULL;
              end else begin
                ram_we = 1'b1;
                if (sel_second) begin
                  second_d = second_q + 1'b1;
                end else begin
                  first_d = first_q + 1'b1;
                end
              end
            end
            wdcm_pkg::ACT_CLEAR: begin
              out_load = 1'b1;
              first_d  = '0;
              second_d = '0;
            end
            wdcm_pkg::ACT_QUERY: begin
              if (out_range) begin
                out_load = 1'b1;
                status_d = wdcm_pkg::ST_RANGE;
              end else if (in_row && in_col) begin
                // Point pair: read both stored points, then run the distance unit
                slot_a_d = AW'(req_i.row);
                slot_b_d = SECOND_BASE + AW'(req_i.column);
                state_d  = T_RDA;
              end else if (in_row || in_col) begin
                out_load = 1'b1;
                cost_d   = cfg.unmatched_cost;
                kind_d   = wdcm_pkg::KIND_UNMATCHED;
              end else begin
                out_load = 1'b1;
                kind_d   = wdcm_pkg::KIND_ZERO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      T_RDA: begin
        state_d = T_RDB;
      end
      T_RDB: begin
        state_d = T_START;
      end
      T_START: begin
        state_d = T_WAIT;
      end
      T_WAIT: begin
        if (dist_rsp.done) begin
          out_load = 1'b1;
          cost_d   = dist_rsp.cost;
          state_d  = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  // Hold the result until the response transfer completes
  assign out_valid_d = out_load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      first_q     <= '0;
      second_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_a_q <= slot_a_d;
    slot_b_q <= slot_b_d;
    if (state_q == T_RDB) begin
      word_a_q <= ram_rdata;
    end
    if (out_load) begin
      cost_q   <= cost_d;
      kind_q   <= kind_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cost       = cost_q;
  assign rsp_o.entry_kind = kind_q;
  assign rsp_o.status     = status_q;

endmodule

@@ rtl/core/wdcm_checker.sv @@
// Port-level checker for the cost matrix top level, attached by bind.
module wdcm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic [wdcm_pkg::ACTION_W-1:0]   req_action_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [wdcm_pkg::COST_W-1:0]     rsp_cost_i,
  input logic [wdcm_pkg::KIND_W-1:0]     rsp_kind_i,
  input logic [wdcm_pkg::STATUS_W-1:0]   rsp_status_i
);

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // Non-query actions produce their result on the next cycle
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_action_i != wdcm_pkg::ACT_QUERY) |=> rsp_valid_i)
    else $error("non-query transfer without result on the next cycle");

  // After a transfer the block either starts a long query or waits on the result
  a_busy_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i || rsp_ready_i)
    else $error("request ready while the previous result cannot drain");

  // A stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("request accepted while result register is stalled");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_cost_i)
      && $stable(rsp_kind_i) && $stable(rsp_status_i))
    else $error("stalled result changed");

endmodule

bind weighted_distance_cost_matrix wdcm_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_action_i (req_i.action),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_cost_i   (rsp_o.cost),
  .rsp_kind_i   (rsp_o.entry_kind),
  .rsp_status_i (rsp_o.status)
);
